/* rtl/kts_pkg.sv */
// kts_pkg: shared types and constants for the keyed table search block
// table geometry, item field widths, mode codes, controller states, command/status structs
// no dependencies

package kts_pkg;

    localparam int DEPTH      = 256;
    localparam int AW         = $clog2(DEPTH);   // slot / position width
    localparam int CW         = AW + 1;          // count width, holds DEPTH itself
    localparam int IW         = AW + 2;          // signed bound width, holds -1
    localparam int KEY_W      = 32;
    localparam int MODE_W     = 2;
    localparam int IN_TDATA_W = ((AW + KEY_W + 7) / 8) * 8;
    localparam int OUT_BITS   = 1 + AW + CW;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_LINEAR = 2'd1,
        MODE_BINARY = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic load_write;   // write key into table
        logic start;        // capture search key and set up bounds
        logic issue_read;   // read the table at the probe slot
        logic compare;      // count the probe and narrow the bounds
        logic finish_hit;   // latch a found result
        logic finish_miss;  // latch a not-found result
        logic push;         // move the result into the output register
    } t_cmd;

    typedef struct packed {
        logic in_range;     // lower bound not above upper bound
        logic match;        // read entry equals search key
    } t_sts;

endpackage

/* rtl/keyed_table_search.sv */
// keyed_table_search: 256-entry signed key table with linear and binary search
// load item: key written at its slot, no result; search item: each probe is a table read, then a compare,
// then the result is pushed from the hold state; binary takes at most 9 probes, linear up to entry_count
// (saturated at 256); the next item is taken once the result has moved into the output register,
// so an output stall also holds back the next item; reset (synchronous, active low) clears entry_count,
// the controller and output valid; the key table is not cleared

module keyed_table_search
    import kts_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CW-1:0]          i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // slot[7:0], key[39:8]
    input  logic [MODE_W-1:0]      s_axis_tuser,   // mode[1:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // found[0], position[8:1], comparisons[17:9]
);

    t_cmd          cmd;
    t_sts          sts;
    t_mode         mode;
    logic          found;
    logic [AW-1:0] position;
    logic [CW-1:0] comparisons;

    assign mode = t_mode'(s_axis_tuser);

    kts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_mode      (mode),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    kts_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_slot        (s_axis_tdata[AW-1:0]),
        .i_key         ($signed(s_axis_tdata[AW+KEY_W-1:AW])),
        .i_binary      (mode == MODE_BINARY),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_found       (found),
        .o_position    (position),
        .o_comparisons (comparisons)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, comparisons, position, found};

endmodule

/* rtl/kts_datapath.sv */
// kts_datapath: key table memory, count register, search bounds, probe counter and result registers
// driven by commands from kts_ctrl; depends on kts_pkg

module kts_datapath
    import kts_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CW-1:0]          i_cfg_wdata,
    input  logic [AW-1:0]          i_slot,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic                   i_binary,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    output logic                   o_found,
    output logic [AW-1:0]          o_position,
    output logic [CW-1:0]          o_comparisons
);

    logic signed [KEY_W-1:0] r_mem [DEPTH];

    logic [CW-1:0]           r_entry_count;
    logic signed [KEY_W-1:0] r_key;
    logic                    r_bin;
    logic [CW-1:0]           r_lo;
    logic signed [IW-1:0]    r_hi;
    logic [AW-1:0]           r_addr;
    logic signed [KEY_W-1:0] r_rdata;
    logic [CW-1:0]           r_cnt;
    logic                    r_found;
    logic [AW-1:0]           r_pos;
    logic                    r_out_found;
    logic [AW-1:0]           r_out_pos;
    logic [CW-1:0]           r_out_cnt;

    logic [CW-1:0] active;
    logic [IW-1:0] bound_sum;
    logic [AW-1:0] probe;

    // counts above the table depth saturate
    assign active    = (r_entry_count > CW'(DEPTH)) ? CW'(DEPTH) : r_entry_count;
    assign bound_sum = {1'b0, r_lo} + r_hi;
    assign probe     = r_bin ? bound_sum[AW:1] : r_lo[AW-1:0];

    assign o_sts.in_range = $signed({1'b0, r_lo}) <= r_hi;
    assign o_sts.match    = (r_rdata == r_key);

    assign o_found       = r_out_found;
    assign o_position    = r_out_pos;
    assign o_comparisons = r_out_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_write) begin
            r_mem[i_slot] <= i_key;
        end
        if (i_cmd.issue_read) begin
            r_rdata <= r_mem[probe];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key <= i_key;
            r_bin <= i_binary;
            r_lo  <= '0;
            r_hi  <= $signed(IW'({1'b0, active}) - IW'(1));
            r_cnt <= '0;
        end
        if (i_cmd.issue_read) begin
            r_addr <= probe;
        end
        if (i_cmd.compare) begin
            r_cnt <= r_cnt + CW'(1);
            if (!o_sts.match) begin
                // linear always moves up; binary moves up when entry is below key
                if (!r_bin || (r_rdata < r_key)) begin
                    r_lo <= {1'b0, r_addr} + CW'(1);
                end else begin
                    r_hi <= $signed(IW'({2'b00, r_addr}) - IW'(1));
                end
            end
        end
        if (i_cmd.finish_hit) begin
            r_found <= 1'b1;
            r_pos   <= r_addr;
        end
        if (i_cmd.finish_miss) begin
            r_found <= 1'b0;
            r_pos   <= '0;
        end
        if (i_cmd.push) begin
            r_out_found <= r_found;
            r_out_pos   <= r_pos;
            r_out_cnt   <= (i_cmd.finish_hit) ? r_cnt : r_cnt;
        end
    end

endmodule

/* rtl/kts_ctrl.sv */
// kts_ctrl: controller state machine for the keyed table search
// sequences table loads, probe read/compare steps and the output handshake; depends on kts_pkg

module kts_ctrl
    import kts_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  t_mode  i_mode,
    output logic   o_in_ready,
    input  logic   i_out_ready,
    output logic   o_out_valid,
    input  t_sts   i_sts,
    output t_cmd   o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_in_ready  = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_mode)
                        MODE_LOAD: begin
                            o_cmd.load_write = 1'b1;
                        end
                        MODE_LINEAR, MODE_BINARY: begin
                            o_cmd.start = 1'b1;
                            n_state     = ST_READ;
                        end
                        default: begin
                            // unused mode code: item is dropped
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (i_sts.in_range) begin
                    o_cmd.issue_read = 1'b1;
                    n_state          = ST_CMP;
                end else begin
                    o_cmd.finish_miss = 1'b1;
                    n_state           = ST_HOLD;
                end
            end
            ST_CMP: begin
                o_cmd.compare = 1'b1;
                if (i_sts.match) begin
                    o_cmd.finish_hit = 1'b1;
                    n_state          = ST_HOLD;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

/* rtl/kts_checker.sv */
// kts_checker: port-level assertions for keyed_table_search, bound to the top level
// depends on kts_pkg

module kts_checker
    import kts_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic          found;
    logic [AW-1:0] position;
    logic [CW-1:0] comparisons;

    assign found       = m_axis_tdata[0];
    assign position    = m_axis_tdata[AW:1];
    assign comparisons = m_axis_tdata[OUT_BITS-1:AW+1];

    // no result left over from before reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !found |-> position == '0)
        else $error("miss with nonzero position");

    a_hit_probes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && found |-> comparisons != '0)
        else $error("hit without any comparison");

    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> comparisons <= CW'(DEPTH))
        else $error("comparison count above table depth");

endmodule

bind keyed_table_search kts_checker u_kts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
